// ----- sv/dstwr_pkg.sv -----
// shared constants, types and codes of the ranging distance average unit
`default_nettype none
package dstwr_pkg;

    // field widths
    localparam int TS_BITS_DEF = 40;
    localparam int FLIGHT_W    = 41;
    localparam int DIST_W      = 32;
    localparam int MEAN_W      = 31;
    localparam int MPT_W       = 32;
    localparam int UPL_W       = 31;
    localparam int BATCH_W     = 16;
    localparam int SUM_W       = 48;
    localparam int NUM_TS      = 6;
    localparam int OUT_DATA_W  = 104;
    localparam int OUT_USER_W  = 3;
    localparam int MUL_STEPS   = 4;

    // register file
    localparam int CFG_AW = 4;
    localparam int CFG_DW = 32;
    localparam logic [1:0] REG_MPT   = 2'd0;
    localparam logic [1:0] REG_UPL   = 2'd1;
    localparam logic [1:0] REG_BATCH = 2'd2;

    localparam logic [MPT_W-1:0]   MPT_RST   = 32'd20145114;
    localparam logic [UPL_W-1:0]   UPL_RST   = 31'd65536000;
    localparam logic [BATCH_W-1:0] BATCH_RST = 16'd1000;

    // controller states
    typedef enum logic [11:0] {
        S_IDLE   = 12'b0000_0000_0001,
        S_LOAD   = 12'b0000_0000_0010,
        S_MULP   = 12'b0000_0000_0100,
        S_MULM   = 12'b0000_0000_1000,
        S_NUM    = 12'b0000_0001_0000,
        S_DIV    = 12'b0000_0010_0000,
        S_FLIGHT = 12'b0000_0100_0000,
        S_MULS   = 12'b0000_1000_0000,
        S_DIST   = 12'b0001_0000_0000,
        S_MINIT  = 12'b0010_0000_0000,
        S_MDIV   = 12'b0100_0000_0000,
        S_EMIT   = 12'b1000_0000_0000
    } t_state;

    // datapath operations
    typedef enum logic [3:0] {
        OP_IDLE,
        OP_LOAD,
        OP_MUL,
        OP_NUM,
        OP_DIV,
        OP_FLIGHT,
        OP_DIST,
        OP_MEAN_INIT,
        OP_EMIT
    } t_op;

    // multiplier operand pairs
    typedef enum logic [1:0] {
        MSEL_P,
        MSEL_M,
        MSEL_S
    } t_msel;

    typedef struct packed {
        logic        capture;
        t_op         op;
        t_msel       msel;
        logic [2:0]  step;
    } t_cmd;

    typedef struct packed {
        logic zero_div;
        logic mean_needed;
        logic out_free;
    } t_status;

endpackage
`default_nettype wire

// ----- sv/dstwr_ctrl.sv -----
// sequencer for load, multiplies, divisions, scaling and result hand-off
`default_nettype none
module dstwr_ctrl #(
    parameter int TS_BITS = dstwr_pkg::TS_BITS_DEF
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_ready,
    input  dstwr_pkg::t_status i_status,
    output dstwr_pkg::t_cmd    o_cmd
);
    localparam int OPW  = (TS_BITS > dstwr_pkg::FLIGHT_W) ? TS_BITS : dstwr_pkg::FLIGHT_W;
    localparam int ACCW = 2 * OPW;
    localparam int CW   = $clog2(ACCW + 1);

    dstwr_pkg::t_state r_state, n_state;
    logic [CW-1:0]     r_cnt, n_cnt;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dstwr_pkg::S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assign o_in_ready = (r_state == dstwr_pkg::S_IDLE);

    // next state and commands
    always_comb begin
        n_state       = r_state;
        n_cnt         = r_cnt;
        o_cmd.capture = 1'b0;
        o_cmd.op      = dstwr_pkg::OP_IDLE;
        o_cmd.msel    = dstwr_pkg::MSEL_P;
        o_cmd.step    = r_cnt[2:0];
        case (r_state)
            dstwr_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = dstwr_pkg::S_LOAD;
                end
            end
            dstwr_pkg::S_LOAD: begin
                o_cmd.op = dstwr_pkg::OP_LOAD;
                n_cnt    = '0;
                n_state  = dstwr_pkg::S_MULP;
            end
            dstwr_pkg::S_MULP: begin
                if (r_cnt == '0 && i_status.zero_div) begin
                    n_state = dstwr_pkg::S_EMIT;
                end else begin
                    o_cmd.op   = dstwr_pkg::OP_MUL;
                    o_cmd.msel = dstwr_pkg::MSEL_P;
                    if (r_cnt == CW'(dstwr_pkg::MUL_STEPS)) begin
                        n_cnt   = '0;
                        n_state = dstwr_pkg::S_MULM;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end
            dstwr_pkg::S_MULM: begin
                o_cmd.op   = dstwr_pkg::OP_MUL;
                o_cmd.msel = dstwr_pkg::MSEL_M;
                if (r_cnt == CW'(dstwr_pkg::MUL_STEPS)) begin
                    n_cnt   = '0;
                    n_state = dstwr_pkg::S_NUM;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            dstwr_pkg::S_NUM: begin
                o_cmd.op = dstwr_pkg::OP_NUM;
                n_cnt    = '0;
                n_state  = dstwr_pkg::S_DIV;
            end
            dstwr_pkg::S_DIV: begin
                o_cmd.op = dstwr_pkg::OP_DIV;
                if (r_cnt == CW'(ACCW - 1)) begin
                    n_cnt   = '0;
                    n_state = dstwr_pkg::S_FLIGHT;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            dstwr_pkg::S_FLIGHT: begin
                o_cmd.op = dstwr_pkg::OP_FLIGHT;
                n_cnt    = '0;
                n_state  = dstwr_pkg::S_MULS;
            end
            dstwr_pkg::S_MULS: begin
                o_cmd.op   = dstwr_pkg::OP_MUL;
                o_cmd.msel = dstwr_pkg::MSEL_S;
                if (r_cnt == CW'(dstwr_pkg::MUL_STEPS)) begin
                    n_cnt   = '0;
                    n_state = dstwr_pkg::S_DIST;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            dstwr_pkg::S_DIST: begin
                o_cmd.op = dstwr_pkg::OP_DIST;
                n_state  = dstwr_pkg::S_MINIT;
            end
            dstwr_pkg::S_MINIT: begin
                o_cmd.op = dstwr_pkg::OP_MEAN_INIT;
                n_cnt    = '0;
                n_state  = i_status.mean_needed ? dstwr_pkg::S_MDIV : dstwr_pkg::S_EMIT;
            end
            dstwr_pkg::S_MDIV: begin
                o_cmd.op = dstwr_pkg::OP_DIV;
                if (r_cnt == CW'(dstwr_pkg::SUM_W - 1)) begin
                    n_cnt   = '0;
                    n_state = dstwr_pkg::S_EMIT;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            dstwr_pkg::S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.op = dstwr_pkg::OP_EMIT;
                    n_state  = dstwr_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = dstwr_pkg::S_IDLE;
                n_cnt   = '0;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- sv/dstwr_dp.sv -----
// datapath: intervals, shared multiplier, restoring divider, scaling, batch sum
`default_nettype none
module dstwr_dp #(
    parameter int TS_BITS = dstwr_pkg::TS_BITS_DEF,
    parameter int IN_W    = 240
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  dstwr_pkg::t_cmd                       i_cmd,
    output dstwr_pkg::t_status                    o_status,
    input  wire  [IN_W-1:0]                       i_in_data,
    input  wire  [dstwr_pkg::MPT_W-1:0]           i_mpt,
    input  wire  [dstwr_pkg::UPL_W-1:0]           i_upl,
    input  wire  [dstwr_pkg::BATCH_W-1:0]         i_batch,
    output logic                                  o_out_valid,
    input  wire                                   i_out_ready,
    output logic [dstwr_pkg::OUT_DATA_W-1:0]      o_out_data,
    output logic [dstwr_pkg::OUT_USER_W-1:0]      o_out_user
);
    localparam int FW   = dstwr_pkg::FLIGHT_W;
    localparam int OPW  = (TS_BITS > FW) ? TS_BITS : FW;
    localparam int HW   = (OPW + 1) / 2;
    localparam int ACCW = 2 * OPW;
    localparam int DENW = TS_BITS + 2;
    localparam int RW   = DENW + 1;
    localparam int QW   = FW + 1;
    localparam int SW   = dstwr_pkg::SUM_W;
    localparam int DW   = dstwr_pkg::DIST_W;

    // captured timestamps
    logic [TS_BITS-1:0] r_ts [dstwr_pkg::NUM_TS];
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            for (int k = 0; k < dstwr_pkg::NUM_TS; k++) begin
                r_ts[k] <= i_in_data[k*TS_BITS +: TS_BITS];
            end
        end
    end

    // intervals and their sum
    logic [TS_BITS-1:0] c_ra, c_rb, c_da, c_db;
    logic [DENW-1:0]    c_den;
    assign c_ra  = r_ts[4] - r_ts[3];
    assign c_rb  = r_ts[2] - r_ts[1];
    assign c_da  = r_ts[1] - r_ts[0];
    assign c_db  = r_ts[5] - r_ts[4];
    assign c_den = DENW'(c_ra) + DENW'(c_rb) + DENW'(c_da) + DENW'(c_db);

    logic [TS_BITS-1:0] r_ra, r_rb, r_da, r_db;
    logic [DENW-1:0]    r_den;
    logic               r_zero;

    // shared multiplier operands
    logic [2*HW-1:0] c_a, c_b;
    logic [HW-1:0]   c_ah, c_bh;
    logic [FW-1:0]   r_mag;
    always_comb begin
        case (i_cmd.msel)
            dstwr_pkg::MSEL_P: begin
                c_a = (2*HW)'(r_ra);
                c_b = (2*HW)'(r_rb);
            end
            dstwr_pkg::MSEL_M: begin
                c_a = (2*HW)'(r_da);
                c_b = (2*HW)'(r_db);
            end
            dstwr_pkg::MSEL_S: begin
                c_a = (2*HW)'(r_mag);
                c_b = (2*HW)'(i_mpt);
            end
            default: begin
                c_a = '0;
                c_b = '0;
            end
        endcase
        c_ah = i_cmd.step[1] ? c_a[2*HW-1:HW] : c_a[HW-1:0];
        c_bh = i_cmd.step[0] ? c_b[2*HW-1:HW] : c_b[HW-1:0];
    end

    logic [2*HW-1:0] r_pp;
    logic [1:0]      r_pp_k;
    logic [ACCW-1:0] r_acc, r_p, c_pp_sh;
    always_comb begin
        case (r_pp_k)
            2'd0:    c_pp_sh = ACCW'(r_pp);
            2'd3:    c_pp_sh = ACCW'(r_pp) << (2 * HW);
            default: c_pp_sh = ACCW'(r_pp) << HW;
        endcase
    end

    // numerator magnitude
    logic            c_p_ge;
    assign c_p_ge = (r_p >= r_acc);

    // divider step
    logic [ACCW-1:0] r_num;
    logic [RW-1:0]   r_rem, c_sh, c_den_ext;
    logic            c_ge;
    logic [QW-1:0]   r_q;
    logic            r_ovf, r_neg;
    assign c_sh      = {r_rem[RW-2:0], r_num[ACCW-1]};
    assign c_den_ext = RW'(r_den);
    assign c_ge      = (c_sh >= c_den_ext);

    // flight saturation
    localparam logic [FW-1:0] LIM_NEG = {1'b1, {(FW-1){1'b0}}};
    localparam logic [FW-1:0] LIM_POS = {1'b0, {(FW-1){1'b1}}};
    logic          c_big;
    logic [FW-1:0] c_qf, c_mag;
    logic          c_negf;
    assign c_big = r_ovf | r_q[QW-1];
    assign c_qf  = r_q[FW-1:0];
    always_comb begin
        if (r_neg) begin
            c_mag = (c_big || c_qf > LIM_NEG) ? LIM_NEG : c_qf;
        end else begin
            c_mag = (c_big || c_qf > LIM_POS) ? LIM_POS : c_qf;
        end
        c_negf = r_neg && (c_mag != '0);
    end

    // distance scaling and window
    localparam logic [DW-1:0] DNEG = {1'b1, {(DW-1){1'b0}}};
    localparam logic [DW-1:0] DPOS = {1'b0, {(DW-1){1'b1}}};
    logic [ACCW-1:0]              c_dfull;
    logic [DW-1:0]                c_dmag, c_dist;
    logic                         c_accept, c_complete;
    logic [SW-1:0]                r_sum;
    logic [dstwr_pkg::BATCH_W-1:0] r_cnt, c_cnt_new, c_target;
    logic                         r_done;
    assign c_dfull = r_acc >> 16;
    always_comb begin
        if (r_neg) begin
            c_dmag = (c_dfull > ACCW'(DNEG)) ? DNEG : c_dfull[DW-1:0];
            c_dist = DW'(0) - c_dmag;
        end else begin
            c_dmag = (c_dfull > ACCW'(DPOS)) ? DPOS : c_dfull[DW-1:0];
            c_dist = c_dmag;
        end
    end
    assign c_accept   = !r_done && !r_neg && (c_dmag != '0) && (c_dmag < {1'b0, i_upl});
    assign c_cnt_new  = r_cnt + 1'b1;
    assign c_target   = (i_batch == '0) ? dstwr_pkg::BATCH_W'(1) : i_batch;
    assign c_complete = (c_cnt_new >= c_target) && (c_cnt_new != '0);

    logic [FW-1:0] r_flight;
    logic [DW-1:0] r_dist;
    logic          r_accd, r_mneed;

    // working registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            dstwr_pkg::OP_LOAD: begin
                r_ra     <= c_ra;
                r_rb     <= c_rb;
                r_da     <= c_da;
                r_db     <= c_db;
                r_den    <= c_den;
                r_zero   <= (c_den == '0);
                r_flight <= '0;
                r_dist   <= '0;
                r_neg    <= 1'b0;
            end
            dstwr_pkg::OP_MUL: begin
                if (i_cmd.step == 3'd0 && i_cmd.msel == dstwr_pkg::MSEL_M) begin
                    r_p <= r_acc;
                end
                if (i_cmd.step == 3'd0) begin
                    r_acc <= '0;
                end else begin
                    r_acc <= r_acc + c_pp_sh;
                end
                if (i_cmd.step < 3'(dstwr_pkg::MUL_STEPS)) begin
                    r_pp   <= c_ah * c_bh;
                    r_pp_k <= i_cmd.step[1:0];
                end
            end
            dstwr_pkg::OP_NUM: begin
                r_num <= c_p_ge ? (r_p - r_acc) : (r_acc - r_p);
                r_neg <= !c_p_ge;
                r_rem <= '0;
                r_q   <= '0;
                r_ovf <= 1'b0;
            end
            dstwr_pkg::OP_DIV: begin
                r_rem <= c_ge ? (c_sh - c_den_ext) : c_sh;
                r_q   <= {r_q[QW-2:0], c_ge};
                r_ovf <= r_ovf | r_q[QW-1];
                r_num <= r_num << 1;
            end
            dstwr_pkg::OP_FLIGHT: begin
                r_mag    <= c_mag;
                r_neg    <= c_negf;
                r_flight <= c_negf ? (FW'(0) - c_mag) : c_mag;
            end
            dstwr_pkg::OP_DIST: begin
                r_dist <= c_dist;
            end
            dstwr_pkg::OP_MEAN_INIT: begin
                if (r_mneed) begin
                    r_num <= ACCW'(r_sum) << (ACCW - SW);
                    r_den <= DENW'(r_cnt);
                    r_rem <= '0;
                    r_q   <= '0;
                    r_ovf <= 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    // batch state and per-item flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_cnt   <= '0;
            r_done  <= 1'b0;
            r_accd  <= 1'b0;
            r_mneed <= 1'b0;
        end else if (i_cmd.op == dstwr_pkg::OP_LOAD) begin
            r_accd  <= 1'b0;
            r_mneed <= 1'b0;
        end else if (i_cmd.op == dstwr_pkg::OP_DIST && c_accept) begin
            r_sum  <= r_sum + SW'(c_dmag);
            r_cnt  <= c_cnt_new;
            r_accd <= 1'b1;
            if (c_complete) begin
                r_mneed <= 1'b1;
                r_done  <= 1'b1;
            end
        end
    end

    // output register
    logic [dstwr_pkg::MEAN_W-1:0] c_mean;
    assign c_mean = r_mneed ? r_q[dstwr_pkg::MEAN_W-1:0] : '0;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.op == dstwr_pkg::OP_EMIT) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == dstwr_pkg::OP_EMIT) begin
            o_out_data <= {c_mean, r_dist, r_flight};
            o_out_user <= {r_mneed, r_zero, r_accd};
        end
    end

    assign o_status.zero_div    = r_zero;
    assign o_status.mean_needed = r_mneed;
    assign o_status.out_free    = !o_out_valid || i_out_ready;

endmodule
`default_nettype wire

// ----- sv/ds_twr_distance_average_unit.sv -----
// top level: register file, sequencer and datapath of the ranging distance average unit
//
//  channel   | direction | handshake                  | contents
//  s_axis    | in        | tvalid / tready            | six timestamps of one exchange
//  m_axis    | out       | tvalid / tready            | flight, distance, mean + flags
//  apb       | in        | psel / penable / pready=1  | metres per tick, limit, batch
//
// one exchange at a time: the run per item is set by the one-bit-a-cycle divider over
// the product numerator; the item that completes a batch adds the mean division over
// the 48-bit batch sum; a zero interval sum skips the multiplies and divisions and
// goes straight to the result hand-off
// synchronous active-low reset clears control state and loads register defaults
// the next item is taken while a finished result still waits on m_axis
`default_nettype none
module ds_twr_distance_average_unit #(
    parameter int TS_BITS = dstwr_pkg::TS_BITS_DEF
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // resp_poll_rx, resp_reply_tx, resp_final_rx, init_poll_tx, init_reply_rx,
    // init_final_tx, TS_BITS each, from bit 0 up
    input  wire  [((6*TS_BITS+7)/8)*8-1:0]      i_s_axis_tdata,
    output logic                                o_m_axis_tvalid,
    input  wire                                 i_m_axis_tready,
    // flight_ticks[40:0], distance_q16[72:41], mean_q16[103:73]
    output logic [dstwr_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata,
    // accepted[0], zero_divisor[1], mean_valid[2]
    output logic [dstwr_pkg::OUT_USER_W-1:0]    o_m_axis_tuser,
    input  wire                                 psel,
    input  wire                                 penable,
    input  wire                                 pwrite,
    input  wire  [dstwr_pkg::CFG_AW-1:0]        paddr,
    input  wire  [dstwr_pkg::CFG_DW-1:0]        pwdata,
    output logic [dstwr_pkg::CFG_DW-1:0]        prdata,
    output logic                                pready
);
    localparam int IN_W = ((6 * TS_BITS + 7) / 8) * 8;

    logic [dstwr_pkg::MPT_W-1:0]   r_mpt;
    logic [dstwr_pkg::UPL_W-1:0]   r_upl;
    logic [dstwr_pkg::BATCH_W-1:0] r_batch;
    logic [1:0]                    c_reg;
    logic                          c_wr;

    assign pready = 1'b1;
    assign c_reg  = paddr[dstwr_pkg::CFG_AW-1:2];
    assign c_wr   = psel & penable & pwrite;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mpt   <= dstwr_pkg::MPT_RST;
            r_upl   <= dstwr_pkg::UPL_RST;
            r_batch <= dstwr_pkg::BATCH_RST;
        end else if (c_wr) begin
            case (c_reg)
                dstwr_pkg::REG_MPT:   r_mpt   <= pwdata[dstwr_pkg::MPT_W-1:0];
                dstwr_pkg::REG_UPL:   r_upl   <= pwdata[dstwr_pkg::UPL_W-1:0];
                dstwr_pkg::REG_BATCH: r_batch <= pwdata[dstwr_pkg::BATCH_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // register reads
    always_comb begin
        case (c_reg)
            dstwr_pkg::REG_MPT:   prdata = dstwr_pkg::CFG_DW'(r_mpt);
            dstwr_pkg::REG_UPL:   prdata = dstwr_pkg::CFG_DW'(r_upl);
            dstwr_pkg::REG_BATCH: prdata = dstwr_pkg::CFG_DW'(r_batch);
            default:              prdata = '0;
        endcase
    end

    dstwr_pkg::t_cmd    w_cmd;
    dstwr_pkg::t_status w_status;

    dstwr_ctrl #(
        .TS_BITS (TS_BITS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    dstwr_dp #(
        .TS_BITS (TS_BITS),
        .IN_W    (IN_W)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_in_data   (i_s_axis_tdata),
        .i_mpt       (r_mpt),
        .i_upl       (r_upl),
        .i_batch     (r_batch),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out_data  (o_m_axis_tdata),
        .o_out_user  (o_m_axis_tuser)
    );

endmodule
`default_nettype wire

// ----- sim/tb_top.sv -----
// self-checking testbench of the ranging distance average unit
`timescale 1ns / 100ps
module tb_top;
    import dstwr_pkg::*;

    localparam int TSW = 40;
    localparam logic [1:0] REG_UNUSED = 2'd3;

    typedef logic [TSW-1:0] ts_t;
    // packed so that resp_poll_rx lands in the lowest bits of tdata
    typedef struct packed {
        ts_t init_final_tx;
        ts_t init_reply_rx;
        ts_t init_poll_tx;
        ts_t resp_final_rx;
        ts_t resp_reply_tx;
        ts_t resp_poll_rx;
    } xchg_t;

    typedef struct {
        logic [FLIGHT_W-1:0] flight;
        logic [DIST_W-1:0]   dist_q;
        logic                acc;
        logic                zdiv;
        logic                mvalid;
        logic [MEAN_W-1:0]   mean;
    } range_res_t;

    // ranging predictor plus the queue of pending range results
    class range_scoreboard;
        logic [MPT_W-1:0]   mpt;
        logic [UPL_W-1:0]   upl;
        logic [BATCH_W-1:0] batch;
        logic [SUM_W-1:0]   dist_sum;
        logic [BATCH_W-1:0] acc_cnt;
        logic               done;
        range_res_t         pending_q[$];
        int errors, n_in, n_out, n_acc, n_zdiv, n_mean, n_neg;

        function new();
            mpt = MPT_RST; upl = UPL_RST; batch = BATCH_RST;
            dist_sum = '0; acc_cnt = '0; done = 1'b0;
            errors = 0; n_in = 0; n_out = 0; n_acc = 0; n_zdiv = 0; n_mean = 0; n_neg = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                REG_MPT:   mpt = val[MPT_W-1:0];
                REG_UPL:   upl = val[UPL_W-1:0];
                REG_BATCH: batch = val[BATCH_W-1:0];
                default: ;
            endcase
        endfunction

        function void report(string what, logic [127:0] got, logic [127:0] exp_v);
            errors++;
            $display("mismatch at result %0d: %s got %0h exp %0h", n_out, what, got, exp_v);
        endfunction

        // compute the expected result of one accepted exchange
        function void note_input(xchg_t x);
            logic [127:0] ra, rb, da, db, den, p, m, num, mag, prod, dmag;
            logic [TSW-1:0] t;
            logic neg;
            logic [BATCH_W-1:0] target;
            range_res_t r;
            t = x.init_reply_rx - x.init_poll_tx;  ra = t;
            t = x.resp_final_rx - x.resp_reply_tx; rb = t;
            t = x.resp_reply_tx - x.resp_poll_rx;  da = t;
            t = x.init_final_tx - x.init_reply_rx; db = t;
            den = ra + rb + da + db;
            r.flight = '0; r.dist_q = '0; r.acc = 0; r.mvalid = 0; r.mean = '0;
            r.zdiv = (den == 0);
            n_in++;
            if (r.zdiv) n_zdiv++;
            else begin
                p = ra * rb;
                m = da * db;
                neg = (m > p);
                num = neg ? m - p : p - m;
                mag = num / den;
                if (mag > 128'hFFFF_FFFF_FFFF_FFFF) mag = 128'hFFFF_FFFF_FFFF_FFFF;
                if (neg && mag > (128'd1 << 40)) mag = 128'd1 << 40;
                if (!neg && mag > (128'd1 << 40) - 1) mag = (128'd1 << 40) - 1;
                if (mag == 0) neg = 0;
                r.flight = neg ? FLIGHT_W'(-mag) : FLIGHT_W'(mag);
                prod = mag * {96'd0, mpt};
                dmag = prod >> 16;
                if (dmag > 128'hFFFF_FFFF_FFFF_FFFF) dmag = 128'hFFFF_FFFF_FFFF_FFFF;
                if (neg) begin
                    if (dmag > 128'h8000_0000) dmag = 128'h8000_0000;
                    r.dist_q = DIST_W'(-dmag);
                    n_neg++;
                end else begin
                    if (dmag > 128'h7FFF_FFFF) dmag = 128'h7FFF_FFFF;
                    r.dist_q = DIST_W'(dmag);
                end
                if (!done && !neg && dmag > 0 && dmag < {97'd0, upl}) begin
                    target = (batch == 0) ? BATCH_W'(1) : batch;
                    r.acc = 1;
                    n_acc++;
                    dist_sum = dist_sum + SUM_W'(dmag);
                    acc_cnt = acc_cnt + 1'b1;
                    if (acc_cnt >= target && acc_cnt != 0) begin
                        r.mean = MEAN_W'(dist_sum / acc_cnt);
                        r.mvalid = 1;
                        done = 1;
                        n_mean++;
                    end
                end
            end
            pending_q.push_back(r);
        endfunction

        // compare one output transaction with the oldest expectation
        function void check(logic [OUT_DATA_W-1:0] d, logic [OUT_USER_W-1:0] u);
            range_res_t r;
            n_out++;
            if (pending_q.size() == 0) begin
                report("unexpected result", d, 0);
                return;
            end
            r = pending_q.pop_front();
            if (d[40:0] !== r.flight)   report("flight_ticks", d[40:0], r.flight);
            if (d[72:41] !== r.dist_q)  report("distance_q16", d[72:41], r.dist_q);
            if (d[103:73] !== r.mean)   report("mean_q16", d[103:73], r.mean);
            if (u[0] !== r.acc)         report("accepted", u[0], r.acc);
            if (u[1] !== r.zdiv)        report("zero_divisor", u[1], r.zdiv);
            if (u[2] !== r.mvalid)      report("mean_valid", u[2], r.mvalid);
        endfunction
    endclass

    logic i_clk, i_rst_n;
    logic s_tvalid, m_tready;
    logic [6*TSW-1:0] s_tdata;
    logic s_tready, m_tvalid;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [OUT_USER_W-1:0] m_tuser;
    logic psel, penable, pwrite;
    logic [CFG_AW-1:0] paddr;
    logic [CFG_DW-1:0] pwdata, prdata;
    logic pready;

    range_scoreboard sb;
    bit no_idle;
    bit hold_req;

    ds_twr_distance_average_unit i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_tvalid), .o_s_axis_tready(s_tready), .i_s_axis_tdata(s_tdata),
        .o_m_axis_tvalid(m_tvalid), .i_m_axis_tready(m_tready),
        .o_m_axis_tdata(m_tdata), .o_m_axis_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // clock
    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #10_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic ts_t rand_ts();
        return {8'($urandom), 32'($urandom)};
    endfunction

    // one well-formed exchange; flight may be negative, reply delays as given
    function automatic xchg_t make_xchg(ts_t t0, ts_t r0, int tof, ts_t dly_a, ts_t dly_b,
                                        int noise);
        xchg_t x;
        x.init_poll_tx  = t0;
        x.resp_poll_rx  = r0;
        x.resp_reply_tx = r0 + dly_a;
        x.init_reply_rx = t0 + dly_a + ts_t'(2 * tof) + ts_t'(noise);
        x.init_final_tx = x.init_reply_rx + dly_b;
        x.resp_final_rx = x.resp_reply_tx + dly_b + ts_t'(2 * tof);
        return x;
    endfunction

    function automatic xchg_t rand_xchg();
        xchg_t x;
        int sel;
        ts_t v;
        sel = $urandom_range(0, 99);
        if (sel < 70)
            x = make_xchg(rand_ts(), rand_ts(), $urandom_range(0, 3000),
                          ts_t'($urandom_range(1, 1 << 20)), ts_t'($urandom_range(1, 1 << 20)),
                          $urandom_range(0, 40) - 20);
        else if (sel < 78)
            x = make_xchg(rand_ts(), rand_ts(), -$urandom_range(1, 3000),
                          ts_t'($urandom_range(10000, 1 << 20)),
                          ts_t'($urandom_range(10000, 1 << 20)), 0);
        else if (sel < 86) begin
            v = rand_ts();
            x = {6{v}};
        end else
            x = {rand_ts(), rand_ts(), rand_ts(), rand_ts(), rand_ts(), rand_ts()};
        return x;
    endfunction

    // drive one exchange and wait until the block takes it
    task automatic send_xchg(xchg_t x);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= x;
        do @(posedge i_clk); while (!s_tready);
        sb.note_input(x);
    endtask

    task automatic run_random(int n);
        for (int i = 0; i < n; i++) send_xchg(rand_xchg());
        s_tvalid <= 1'b0;
    endtask

    // wait for every pending result, then let the block settle
    task automatic drain();
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic apb_write(logic [1:0] idx, logic [31:0] val);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.write_reg(idx, val);
    endtask

    // result side: random stalls, one long hold on request
    initial begin
        int stall;
        m_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 7);
            if (hold_req) begin
                stall = 800;
                hold_req = 0;
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            do @(posedge i_clk); while (!m_tvalid);
            sb.check(m_tdata, m_tuser);
        end
    end

    // stimulus
    initial begin
        ts_t ones;
        sb = new();
        ones = '1;
        no_idle = 0;
        hold_req = 0;
        s_tvalid = 0; s_tdata = '0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        i_rst_n = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed exchanges at reset settings
        send_xchg('0);
        send_xchg('1);
        send_xchg({6{40'hAA_AAAA_AAAA}});
        send_xchg({40'h55_5555_5555, 40'hAA_AAAA_AAAA, 40'h55_5555_5555,
                   40'hAA_AAAA_AAAA, 40'h55_5555_5555, 40'hAA_AAAA_AAAA});
        send_xchg({ones, 40'd0, ones, 40'd0, ones, 40'd0});
        send_xchg({40'd0, ones, 40'd0, ones, 40'd0, ones});
        send_xchg(make_xchg(40'd0, 40'd0, 0, 40'd1000, 40'd1000, 0));
        send_xchg(make_xchg(40'd100, 40'd5, 1, 40'd1000, 40'd2000, 0));
        send_xchg(make_xchg(ones - 5, ones - 3, 500, 40'd300000, 40'd900000, 0));
        send_xchg(make_xchg(40'd7, ones, 2000, 40'd60000, 40'd40000, 3));
        send_xchg(make_xchg(40'd9, 40'd17, -300, 40'd60000, 40'd40000, 0));
        send_xchg(make_xchg(rand_ts(), rand_ts(), 0, ones, ones, 0));
        send_xchg(make_xchg(40'd0, 40'd0, 1 << 28, 40'd1, 40'd1, 0));
        send_xchg(make_xchg(40'd0, 40'd0, 1 << 20, 40'd1000, 40'd1000, 0));
        send_xchg(make_xchg(rand_ts(), rand_ts(), 1, 40'd1, 40'd0, 0));
        send_xchg({rand_ts(), rand_ts(), rand_ts(), rand_ts(), rand_ts(), rand_ts()});
        s_tvalid <= 1'b0;
        drain();

        // widest scale and window, largest batch, a write to an unused address
        apb_write(REG_MPT, 32'hFFFF_FFFF);
        apb_write(REG_UPL, 32'h7FFF_FFFF);
        apb_write(REG_BATCH, 32'h0000_FFFF);
        apb_write(REG_UNUSED, 32'h0000_0001);
        run_random(300);
        drain();

        // zero scale and zero window: nothing can be accumulated
        apb_write(REG_MPT, 32'h0);
        apb_write(REG_UPL, 32'h0);
        run_random(150);
        drain();

        // random settings, window and batch values wider than the registers
        apb_write(REG_MPT, $urandom | 32'h0100_0000);
        apb_write(REG_UPL, 32'h8000_0000 | 32'($urandom_range(1 << 20, 1 << 30)));
        apb_write(REG_BATCH, 32'hABCD_0000 | 32'hFFFF);
        run_random(300);
        drain();

        // reset-like settings, back-to-back stretch, then a long result stall
        apb_write(REG_MPT, MPT_RST);
        apb_write(REG_UPL, UPL_RST);
        no_idle = 1;
        run_random(150);
        no_idle = 0;
        hold_req = 1;
        run_random(250);
        drain();

        // batch size zero acts as one: the next accumulated distance ends the batch
        apb_write(REG_BATCH, 32'h0);
        run_random(180);
        drain();

        $display("covered %0d exchanges: %0d accumulated, %0d zero divisor, %0d negative flight",
                 sb.n_in, sb.n_acc, sb.n_zdiv, sb.n_neg);
        $display("batch means emitted %0d, results checked %0d", sb.n_mean, sb.n_out);
        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
